// ===== sv/aar_pkg.sv =====
// Shared types, constants and the arctangent table of the axis-angle rotation block.
package aar_pkg;

  localparam int ZW           = 26;
  localparam int CORDIC_STEPS = 20;
  localparam int SQRT_STEPS   = 31;
  localparam int DIV_STEPS    = 31;
  localparam int Q_DEPTH      = 4;
  localparam int Q_AW         = 2;

  localparam logic signed [31:0]   CORDIC_X0 = 32'sd652032874;
  localparam logic signed [ZW-1:0] DEG90     = 26'sd5898240;
  localparam logic signed [ZW-1:0] DEG180    = 26'sd11796480;
  localparam logic signed [ZW-1:0] DEG360    = 26'sd23592960;

  typedef struct packed {
    logic signed [16:0] angle_deg;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               degenerate;
  } out_t;

  typedef struct packed {
    logic [2:0]       sgn;
    logic [2:0][15:0] mag;
    logic             degen;
  } axis_t;

  typedef struct packed {
    axis_t                ax;
    logic [31:0]          n2;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } q_item_t;

  function automatic logic [21:0] atan_q16(input int i);
    logic [21:0] a;
    case (i)
      0:  a = 22'd2949120;
      1:  a = 22'd1740967;
      2:  a = 22'd919879;
      3:  a = 22'd466945;
      4:  a = 22'd234379;
      5:  a = 22'd117304;
      6:  a = 22'd58666;
      7:  a = 22'd29335;
      8:  a = 22'd14668;
      9:  a = 22'd7334;
      10: a = 22'd3667;
      11: a = 22'd1833;
      12: a = 22'd917;
      13: a = 22'd458;
      14: a = 22'd229;
      15: a = 22'd115;
      16: a = 22'd57;
      17: a = 22'd29;
      18: a = 22'd14;
      19: a = 22'd7;
      default: a = 22'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== sv/aar_front.sv =====
// Front end: accepts items, reduces the angle, squares the axis and flags degenerate axes.
module aar_front #(
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  aar_pkg::in_t     in_data,
  input  logic             q_full,
  output logic             q_push,
  output aar_pkg::q_item_t q_item
);

  localparam longint unsigned MOD = 64'd360 << ANGLE_FRAC_BITS;
  localparam longint unsigned OFF = MOD * ((64'd65536 + MOD - 64'd1) / MOD);
  localparam longint unsigned RCP = (64'd1 << 32) / MOD;
  localparam int AW  = $clog2(OFF + 64'd65536);
  localparam int RW  = $clog2(RCP + 64'd1);
  localparam int PW  = AW + RW;
  localparam int QW  = PW - 32;
  localparam int MW  = $clog2(MOD + 64'd1);
  localparam int QMW = QW + MW;
  localparam int SH  = 16 - ANGLE_FRAC_BITS;
  localparam logic [AW-1:0] OFF_V = AW'(OFF);
  localparam logic [AW-1:0] MOD_A = AW'(MOD);
  localparam logic [RW-1:0] RCP_V = RW'(RCP);
  localparam logic [MW-1:0] MOD_M = MW'(MOD);

  logic fe;

  logic              f1_v_r;
  logic [AW-1:0]     f1_a_r;
  logic [PW-1:0]     f1_prod_r;
  logic [2:0][31:0]  f1_sq_r;
  aar_pkg::axis_t    f1_ax_r;

  logic              f2_v_r;
  logic [AW-1:0]     f2_rem_r;
  logic [31:0]       f2_n2_r;
  aar_pkg::axis_t    f2_ax_r;

  logic              f3_v_r;
  aar_pkg::q_item_t  f3_item_r;

  logic signed [AW:0]   a_ext;
  logic [AW-1:0]        a_nxt;
  logic [PW-1:0]        prod_nxt;
  logic signed [31:0]   sqx, sqy, sqz;
  aar_pkg::axis_t       ax_nxt;
  logic [QW-1:0]        quo;
  logic [QMW-1:0]       qm;
  logic [AW-1:0]        rem_nxt;
  logic [31:0]          n2_nxt;
  logic [AW-1:0]        r1;
  logic signed [aar_pkg::ZW-1:0] zq;
  aar_pkg::q_item_t     item_nxt;

  assign fe       = !f3_v_r || !q_full;
  assign in_ready = fe;
  assign q_push   = f3_v_r && !q_full;
  assign q_item   = f3_item_r;

  always_comb begin
    a_ext = $signed({{(AW-16){in_data.angle_deg[16]}}, in_data.angle_deg}) +
            $signed({1'b0, OFF_V});
    a_nxt = a_ext[AW-1:0];
    prod_nxt = PW'(a_nxt) * PW'(RCP_V);
    sqx = in_data.axis_x * in_data.axis_x;
    sqy = in_data.axis_y * in_data.axis_y;
    sqz = in_data.axis_z * in_data.axis_z;
    ax_nxt.sgn = {in_data.axis_z[15], in_data.axis_y[15], in_data.axis_x[15]};
    ax_nxt.mag[0] = in_data.axis_x[15] ? 16'(-in_data.axis_x) : in_data.axis_x;
    ax_nxt.mag[1] = in_data.axis_y[15] ? 16'(-in_data.axis_y) : in_data.axis_y;
    ax_nxt.mag[2] = in_data.axis_z[15] ? 16'(-in_data.axis_z) : in_data.axis_z;
    ax_nxt.degen = (in_data.axis_x == in_data.axis_y) && (in_data.axis_y == in_data.axis_z);
  end

  always_comb begin
    quo     = f1_prod_r[PW-1:32];
    qm      = QMW'(quo) * QMW'(MOD_M);
    rem_nxt = f1_a_r - AW'(qm);
    n2_nxt  = f1_sq_r[0] + f1_sq_r[1] + f1_sq_r[2];
  end

  always_comb begin
    r1 = (f2_rem_r >= MOD_A) ? (f2_rem_r - MOD_A) : f2_rem_r;
    zq = aar_pkg::ZW'(r1) <<< SH;
    if (zq >= aar_pkg::DEG180) begin
      zq = zq - aar_pkg::DEG360;
    end
    item_nxt.ax  = f2_ax_r;
    item_nxt.n2  = f2_n2_r;
    item_nxt.z   = zq;
    item_nxt.neg = 1'b0;
    if (zq > aar_pkg::DEG90) begin
      item_nxt.z   = zq - aar_pkg::DEG180;
      item_nxt.neg = 1'b1;
    end else if (zq < -aar_pkg::DEG90) begin
      item_nxt.z   = zq + aar_pkg::DEG180;
      item_nxt.neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else if (fe) begin
      f1_v_r <= in_valid;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      f1_a_r    <= a_nxt;
      f1_prod_r <= prod_nxt;
      f1_sq_r   <= {sqz, sqy, sqx};
      f1_ax_r   <= ax_nxt;
      f2_rem_r  <= rem_nxt;
      f2_n2_r   <= n2_nxt;
      f2_ax_r   <= f1_ax_r;
      f3_item_r <= item_nxt;
    end
  end

endmodule

// ===== sv/aar_fifo.sv =====
// Short queue between the front end and the arithmetic back end.
module aar_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  aar_pkg::q_item_t item_in,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output aar_pkg::q_item_t item_out
);

  aar_pkg::q_item_t            mem_r [aar_pkg::Q_DEPTH];
  logic [aar_pkg::Q_AW-1:0]    wr_r, rd_r;
  logic [aar_pkg::Q_AW:0]      cnt_r, cnt_nxt;

  assign full     = (cnt_r == (aar_pkg::Q_AW + 1)'(aar_pkg::Q_DEPTH));
  assign valid    = (cnt_r != '0);
  assign item_out = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= item_in;
    end
  end

endmodule

// ===== sv/aar_back.sv =====
// Back end: pipelined square root, sine-cosine, normalizing divides and matrix products.
module aar_back #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  aar_pkg::q_item_t q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output aar_pkg::out_t    out_data
);

  localparam int SH = 30 - OUT_FRAC_BITS;
  localparam logic signed [36:0] HALF = 37'((64'sd1 <<< SH) >>> 1);
  localparam logic signed [36:0] LIM  = 37'(64'sd1 <<< OUT_FRAC_BITS);
  localparam logic signed [35:0] ONE  = 36'(64'sd1 <<< 30);

  typedef struct packed {
    aar_pkg::axis_t                ax;
    logic                          neg;
    logic [31:0]                   n2;
    logic [31:0]                   rem;
    logic [30:0]                   root;
    logic signed [31:0]            x;
    logic signed [31:0]            y;
    logic signed [aar_pkg::ZW-1:0] cz;
  } sq_st_t;

  typedef struct packed {
    logic [2:0]        sgn;
    logic              degen;
    logic signed [31:0] c;
    logic signed [31:0] s;
    logic [30:0]       r;
    logic [2:0][30:0]  rem;
    logic [2:0][30:0]  lo;
    logic [2:0][30:0]  quo;
  } dv_st_t;

  typedef struct packed {
    logic               degen;
    logic signed [31:0] c;
    logic signed [32:0] q;
    logic [5:0][31:0]   p;
    logic [2:0][31:0]   su;
  } m0_st_t;

  typedef struct packed {
    logic               degen;
    logic signed [31:0] c;
    logic [5:0][33:0]   qp;
    logic [2:0][31:0]   su;
  } m1_st_t;

  function automatic logic signed [63:0] rnd30(input logic signed [65:0] v);
    logic signed [65:0] w;
    w = (v + 66'sd536870912) >>> 30;
    return w[63:0];
  endfunction

  function automatic logic [15:0] to_out(input logic signed [35:0] t);
    logic signed [36:0] v;
    v = (37'(t) + HALF) >>> SH;
    if (v > LIM) v = LIM;
    if (v < -LIM) v = -LIM;
    if (v > 37'sd32767) v = 37'sd32767;
    if (v < -37'sd32768) v = -37'sd32768;
    return v[15:0];
  endfunction

  logic en;

  sq_st_t sq_r   [aar_pkg::SQRT_STEPS];
  logic   sq_v_r [aar_pkg::SQRT_STEPS];
  dv_st_t dv_r   [aar_pkg::DIV_STEPS+1];
  logic   dv_v_r [aar_pkg::DIV_STEPS+1];
  m0_st_t m0_r;
  logic   m0_v_r;
  m1_st_t m1_r;
  logic   m1_v_r;
  logic          out_valid_r;
  aar_pkg::out_t out_data_r;

  assign en        = !out_valid_r || out_ready;
  assign q_pop     = en && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  for (genvar k = 0; k < aar_pkg::SQRT_STEPS; k++) begin : g_sq
    sq_st_t      prv, nxt;
    logic        prv_v;
    logic [1:0]  pair;
    logic [33:0] rem2, trial;

    if (k == 0) begin : g_first
      always_comb begin
        prv      = '0;
        prv.ax   = q_item.ax;
        prv.neg  = q_item.neg;
        prv.n2   = q_item.n2;
        prv.x    = aar_pkg::CORDIC_X0;
        prv.cz   = q_item.z;
        prv_v    = q_valid;
      end
    end else begin : g_rest
      assign prv   = sq_r[k-1];
      assign prv_v = sq_v_r[k-1];
    end

    if (k <= 15) begin : g_pair
      assign pair = prv.n2[2*(15-k)+1 : 2*(15-k)];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    always_comb begin
      nxt   = prv;
      rem2  = {prv.rem, pair};
      trial = {1'b0, prv.root, 2'b01};
      if (rem2 >= trial) begin
        nxt.rem  = 32'(rem2 - trial);
        nxt.root = {prv.root[29:0], 1'b1};
      end else begin
        nxt.rem  = rem2[31:0];
        nxt.root = {prv.root[29:0], 1'b0};
      end
      if (k < aar_pkg::CORDIC_STEPS) begin
        if (prv.cz >= 0) begin
          nxt.x  = prv.x - (prv.y >>> k);
          nxt.y  = prv.y + (prv.x >>> k);
          nxt.cz = prv.cz - $signed(aar_pkg::ZW'(aar_pkg::atan_q16(k)));
        end else begin
          nxt.x  = prv.x + (prv.y >>> k);
          nxt.y  = prv.y - (prv.x >>> k);
          nxt.cz = prv.cz + $signed(aar_pkg::ZW'(aar_pkg::atan_q16(k)));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else if (en) begin
        sq_v_r[k] <= prv_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k] <= nxt;
      end
    end
  end

  dv_st_t      d0_nxt;
  logic [60:0] num [3];

  always_comb begin
    d0_nxt       = '0;
    d0_nxt.sgn   = sq_r[aar_pkg::SQRT_STEPS-1].ax.sgn;
    d0_nxt.degen = sq_r[aar_pkg::SQRT_STEPS-1].ax.degen;
    d0_nxt.c     = sq_r[aar_pkg::SQRT_STEPS-1].neg ? -sq_r[aar_pkg::SQRT_STEPS-1].x
                                                   : sq_r[aar_pkg::SQRT_STEPS-1].x;
    d0_nxt.s     = sq_r[aar_pkg::SQRT_STEPS-1].neg ? -sq_r[aar_pkg::SQRT_STEPS-1].y
                                                   : sq_r[aar_pkg::SQRT_STEPS-1].y;
    d0_nxt.r     = sq_r[aar_pkg::SQRT_STEPS-1].root;
    for (int i = 0; i < 3; i++) begin
      num[i] = {sq_r[aar_pkg::SQRT_STEPS-1].ax.mag[i], 45'b0} +
               61'(sq_r[aar_pkg::SQRT_STEPS-1].root >> 1);
      d0_nxt.rem[i] = {1'b0, num[i][60:31]};
      d0_nxt.lo[i]  = num[i][30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[aar_pkg::SQRT_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= d0_nxt;
    end
  end

  for (genvar j = 0; j < aar_pkg::DIV_STEPS; j++) begin : g_dv
    dv_st_t      nxt;
    logic [31:0] rem2 [3];
    logic        ge   [3];

    always_comb begin
      nxt = dv_r[j];
      for (int i = 0; i < 3; i++) begin
        rem2[i] = {dv_r[j].rem[i], dv_r[j].lo[i][30-j]};
        ge[i]   = (rem2[i] >= {1'b0, dv_r[j].r});
        nxt.rem[i] = ge[i] ? 31'(rem2[i] - {1'b0, dv_r[j].r}) : rem2[i][30:0];
        nxt.quo[i] = {dv_r[j].quo[i][29:0], ge[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[j+1] <= nxt;
      end
    end
  end

  logic signed [31:0] u [3];
  m0_st_t             m0_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u[i] = dv_r[aar_pkg::DIV_STEPS].sgn[i] ? -$signed(32'(dv_r[aar_pkg::DIV_STEPS].quo[i]))
                                             : $signed(32'(dv_r[aar_pkg::DIV_STEPS].quo[i]));
    end
    m0_nxt.degen = dv_r[aar_pkg::DIV_STEPS].degen;
    m0_nxt.c     = dv_r[aar_pkg::DIV_STEPS].c;
    m0_nxt.q     = 33'sd1073741824 - 33'(dv_r[aar_pkg::DIV_STEPS].c);
    m0_nxt.p[0]  = 32'(rnd30(66'(u[0]) * 66'(u[0])));
    m0_nxt.p[1]  = 32'(rnd30(66'(u[0]) * 66'(u[1])));
    m0_nxt.p[2]  = 32'(rnd30(66'(u[0]) * 66'(u[2])));
    m0_nxt.p[3]  = 32'(rnd30(66'(u[1]) * 66'(u[1])));
    m0_nxt.p[4]  = 32'(rnd30(66'(u[1]) * 66'(u[2])));
    m0_nxt.p[5]  = 32'(rnd30(66'(u[2]) * 66'(u[2])));
    for (int i = 0; i < 3; i++) begin
      m0_nxt.su[i] = 32'(rnd30(66'(dv_r[aar_pkg::DIV_STEPS].s) * 66'(u[i])));
    end
  end

  m1_st_t m1_nxt;

  always_comb begin
    m1_nxt.degen = m0_r.degen;
    m1_nxt.c     = m0_r.c;
    m1_nxt.su    = m0_r.su;
    for (int i = 0; i < 6; i++) begin
      m1_nxt.qp[i] = 34'(rnd30(66'(m0_r.q) * 66'($signed(m0_r.p[i]))));
    end
  end

  logic signed [35:0] t [9];
  aar_pkg::out_t      out_nxt;

  always_comb begin
    t[0] = 36'($signed(m1_r.qp[0])) + 36'(m1_r.c);
    t[4] = 36'($signed(m1_r.qp[3])) + 36'(m1_r.c);
    t[8] = 36'($signed(m1_r.qp[5])) + 36'(m1_r.c);
    t[1] = 36'($signed(m1_r.qp[1])) - 36'($signed(m1_r.su[2]));
    t[3] = 36'($signed(m1_r.qp[1])) + 36'($signed(m1_r.su[2]));
    t[2] = 36'($signed(m1_r.qp[2])) + 36'($signed(m1_r.su[1]));
    t[6] = 36'($signed(m1_r.qp[2])) - 36'($signed(m1_r.su[1]));
    t[5] = 36'($signed(m1_r.qp[4])) - 36'($signed(m1_r.su[0]));
    t[7] = 36'($signed(m1_r.qp[4])) + 36'($signed(m1_r.su[0]));
    if (m1_r.degen) begin
      for (int i = 0; i < 9; i++) begin
        t[i] = (i % 4 == 0) ? ONE : 36'sd0;
      end
    end
    out_nxt.m00 = to_out(t[0]);
    out_nxt.m01 = to_out(t[1]);
    out_nxt.m02 = to_out(t[2]);
    out_nxt.m10 = to_out(t[3]);
    out_nxt.m11 = to_out(t[4]);
    out_nxt.m12 = to_out(t[5]);
    out_nxt.m20 = to_out(t[6]);
    out_nxt.m21 = to_out(t[7]);
    out_nxt.m22 = to_out(t[8]);
    out_nxt.degenerate = m1_r.degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m0_v_r      <= 1'b0;
      m1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      m0_v_r      <= dv_v_r[aar_pkg::DIV_STEPS];
      m1_v_r      <= m0_v_r;
      out_valid_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0_r       <= m0_nxt;
      m1_r       <= m1_nxt;
      out_data_r <= out_nxt;
    end
  end

endmodule

// ===== sv/axis_angle_rotation_matrix.sv =====
// Top level of the axis-angle rotation matrix block.
// Each input item carries an angle in degrees and an axis vector; each result item
// carries the 3x3 rotation matrix about that axis in signed fixed point, plus a flag
// that marks a zero axis or one parallel to (1,1,1), for which the identity is given.
// Both channels use valid and ready; an item moves when both are high at a clock edge.
// A three-stage front end reduces the angle and squares the axis, then writes into a
// four-entry queue. The back end is a 66-stage pipeline: 31 square-root stages that
// also run the 20 sine-cosine rotations, one numerator stage, 31 divide stages that
// normalize the three axis components, two multiply stages and the output register.
// With no stall, one item is accepted and one result given every cycle. While a
// result waits and the receiver holds out_ready low, the whole back end holds its
// contents; the front end keeps accepting until the queue is full and its last
// stage holds an item, and in_ready then drops. Reset (rst_n low, synchronous)
// empties all stages and the queue.
module axis_angle_rotation_matrix #(
  parameter int OUT_FRAC_BITS   = 14,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  aar_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output aar_pkg::out_t out_data
);

  logic             q_full, q_push, q_pop, q_valid;
  aar_pkg::q_item_t q_in, q_out;

  aar_front #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  aar_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .item_in  (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .item_out (q_out)
  );

  aar_back #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== dv/tb_axis_angle_rotation_matrix.sv =====
// Testbench for the axis-angle rotation matrix block, checked against a predictor.
`timescale 1ns / 100ps

module tb_axis_angle_rotation_matrix;

  localparam int OFB = 14;
  localparam int AFB = 7;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  aar_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  aar_pkg::out_t out_data;

  aar_pkg::out_t matrix_q[$];
  int fail_count = 0;
  bit rx_hold = 1'b0;
  int rx_mode = 0;
  int idle_cycles = 0;

  axis_angle_rotation_matrix #(.OUT_FRAC_BITS(OFB), .ANGLE_FRAC_BITS(AFB)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shr(longint v, int n);
    if (n == 0) return v;
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] to_element(longint t);
    longint v, lim;
    v = round_shr(t, 30 - OFB);
    lim = longint'(1) <<< OFB;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic aar_pkg::out_t rotation_matrix(aar_pkg::in_t it);
    longint ax[3], u[3], m[9];
    longint ang, z, x, y, t, dx, dy, c, s, q, d360;
    logic [63:0] n2, r, mag, qv;
    bit neg;
    aar_pkg::out_t res;
    d360 = longint'(360) * 65536;
    ang = longint'(it.angle_deg);
    ax[0] = longint'(it.axis_x);
    ax[1] = longint'(it.axis_y);
    ax[2] = longint'(it.axis_z);
    n2 = ax[0] * ax[0] + ax[1] * ax[1] + ax[2] * ax[2];
    if (n2 == 0 || (ax[0] == ax[1] && ax[1] == ax[2])) begin
      res = '0;
      res.m00 = to_element(longint'(1) <<< 30);
      res.m11 = res.m00;
      res.m22 = res.m00;
      res.degenerate = 1'b1;
      return res;
    end
    r = int_sqrt(n2 << 30);
    for (int i = 0; i < 3; i++) begin
      mag = ax[i] < 0 ? -ax[i] : ax[i];
      qv = ((mag << 45) + (r >> 1)) / r;
      u[i] = ax[i] < 0 ? -longint'(qv) : longint'(qv);
    end
    z = (ang * (longint'(1) <<< (16 - AFB))) % d360;
    if (z < 0) z += d360;
    if (z >= d360 / 2) z -= d360;
    neg = 1'b0;
    if (z > d360 / 4) begin
      z -= d360 / 2;
      neg = 1'b1;
    end else if (z < -d360 / 4) begin
      z += d360 / 2;
      neg = 1'b1;
    end
    x = 652032874;
    y = 0;
    for (int i = 0; i < aar_pkg::CORDIC_STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        t = x - dx; y = y + dy; z -= longint'(aar_pkg::atan_q16(i));
      end else begin
        t = x + dx; y = y - dy; z += longint'(aar_pkg::atan_q16(i));
      end
      x = t;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
    q = (longint'(1) <<< 30) - c;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i*3+j] = round_shr(q * round_shr(u[i] * u[j], 30), 30) + (i == j ? c : 0);
    m[1] -= round_shr(s * u[2], 30);
    m[3] += round_shr(s * u[2], 30);
    m[2] += round_shr(s * u[1], 30);
    m[6] -= round_shr(s * u[1], 30);
    m[5] -= round_shr(s * u[0], 30);
    m[7] += round_shr(s * u[0], 30);
    res.m00 = to_element(m[0]); res.m01 = to_element(m[1]); res.m02 = to_element(m[2]);
    res.m10 = to_element(m[3]); res.m11 = to_element(m[4]); res.m12 = to_element(m[5]);
    res.m20 = to_element(m[6]); res.m21 = to_element(m[7]); res.m22 = to_element(m[8]);
    res.degenerate = 1'b0;
    return res;
  endfunction

  task automatic send_item(aar_pkg::in_t it);
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    matrix_q.push_back(rotation_matrix(it));
  endtask

  // Bursts of random length, each usually preceded by an idle gap that also drops valid.
  int burst_left = 0;
  task automatic send_paced(aar_pkg::in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    send_item(it);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic signed [16:0] rand_angle();
    return 17'(int'($urandom_range(0, 92160)) - 46080);
  endfunction

  function automatic aar_pkg::in_t rand_item();
    aar_pkg::in_t it;
    it.angle_deg = rand_angle();
    case ($urandom_range(0, 9))
      0: begin
        it.axis_x = 16'($urandom_range(0, 4) - 2);
        it.axis_y = 16'($urandom_range(0, 4) - 2);
        it.axis_z = 16'($urandom_range(0, 4) - 2);
      end
      1: begin
        it.axis_x = 16'($urandom);
        it.axis_y = it.axis_x;
        it.axis_z = it.axis_x;
      end
      2: begin
        it.axis_x = 16'($urandom);
        it.axis_y = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
        it.axis_z = '0;
      end
      3: begin
        it.angle_deg = 17'($urandom);
        it.axis_x = 16'($urandom);
        it.axis_y = 16'($urandom);
        it.axis_z = 16'($urandom);
      end
      default: begin
        it.axis_x = 16'($urandom);
        it.axis_y = 16'($urandom);
        it.axis_z = 16'($urandom);
      end
    endcase
    return it;
  endfunction

  function automatic aar_pkg::in_t mk(int a, int x, int y, int z);
    aar_pkg::in_t it;
    it.angle_deg = 17'(a); it.axis_x = 16'(x); it.axis_y = 16'(y); it.axis_z = 16'(z);
    return it;
  endfunction

  task automatic test_directed();
    send_item(mk(0, 1, 0, 0));
    send_item(mk(90 * 128, 1, 0, 0));
    send_item(mk(-90 * 128, 0, 1, 0));
    send_item(mk(180 * 128, 0, 0, 1));
    send_item(mk(-180 * 128, 0, 0, -1));
    send_item(mk(46080, 32767, 0, 0));
    send_item(mk(-46080, -32768, 0, 0));
    send_item(mk(65535, 0, 0, 0));
    send_item(mk(-65536, 0, 0, 0));
    send_item(mk(45 * 128, 5, 5, 5));
    send_item(mk(30 * 128, -32768, -32768, -32768));
    send_item(mk(120 * 128, 32767, 32767, 32767));
    send_item(mk(91 * 128, -32768, 32767, -32768));
    send_item(mk(-91 * 128, 32767, -32768, 32767));
    send_item(mk(1, 1, 2, 3));
    send_item(mk(-1, -3, 2, -1));
    send_item(mk(270 * 128 + 64, 100, -200, 300));
    send_item(mk(359 * 128 + 127, 0, 32767, -32768));
    send_item(mk(-179 * 128, 1, 1, 0));
    send_item(mk(60 * 128, -1, -1, -1));
    drain_results();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_paced(rand_item());
    drain_results();
  endtask

  task automatic test_backpressure();
    rx_hold = 1'b1;
    for (int i = 0; i < 120; i++) send_item(rand_item());
    rx_hold = 1'b0;
    drain_results();
  endtask

  task automatic test_back_to_back();
    rx_mode = 1;
    for (int i = 0; i < 150; i++) send_item(rand_item());
    rx_mode = 0;
    drain_results();
  endtask

  // The receiver stalls on a random pattern; rx_mode 1 keeps it always ready and rx_hold forces a long fixed hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold) begin
      out_ready <= 1'b0;
      repeat (300) @(posedge clk);
      out_ready <= 1'b1;
      while (rx_hold) @(posedge clk);
    end else if (rx_mode == 1) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 9) < 7);
    end
  end

  always @(posedge clk) begin
    aar_pkg::out_t exp_m;
    if (rst_n && out_valid && out_ready) begin
      if (matrix_q.size() == 0) begin
        $error("result item with no expectation waiting");
        fail_count++;
      end else begin
        exp_m = matrix_q.pop_front();
        if (out_data.m00 !== exp_m.m00) begin
          $error("m00 expected %0d actual %0d", exp_m.m00, out_data.m00); fail_count++;
        end
        if (out_data.m01 !== exp_m.m01) begin
          $error("m01 expected %0d actual %0d", exp_m.m01, out_data.m01); fail_count++;
        end
        if (out_data.m02 !== exp_m.m02) begin
          $error("m02 expected %0d actual %0d", exp_m.m02, out_data.m02); fail_count++;
        end
        if (out_data.m10 !== exp_m.m10) begin
          $error("m10 expected %0d actual %0d", exp_m.m10, out_data.m10); fail_count++;
        end
        if (out_data.m11 !== exp_m.m11) begin
          $error("m11 expected %0d actual %0d", exp_m.m11, out_data.m11); fail_count++;
        end
        if (out_data.m12 !== exp_m.m12) begin
          $error("m12 expected %0d actual %0d", exp_m.m12, out_data.m12); fail_count++;
        end
        if (out_data.m20 !== exp_m.m20) begin
          $error("m20 expected %0d actual %0d", exp_m.m20, out_data.m20); fail_count++;
        end
        if (out_data.m21 !== exp_m.m21) begin
          $error("m21 expected %0d actual %0d", exp_m.m21, out_data.m21); fail_count++;
        end
        if (out_data.m22 !== exp_m.m22) begin
          $error("m22 expected %0d actual %0d", exp_m.m22, out_data.m22); fail_count++;
        end
        if (out_data.degenerate !== exp_m.degenerate) begin
          $error("degenerate expected %0b actual %0b", exp_m.degenerate,
                 out_data.degenerate);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (matrix_q.size() == 0 && !in_valid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** axis_angle_rotation_matrix: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(250);
    test_back_to_back();
    if (matrix_q.size() != 0) begin
      $error("%0d expected results left over", matrix_q.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("** axis_angle_rotation_matrix: PASSED **");
    else
      $display("** axis_angle_rotation_matrix: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/aar_pkg.sv
sv/aar_front.sv
sv/aar_fifo.sv
sv/aar_back.sv
sv/axis_angle_rotation_matrix.sv
dv/tb_axis_angle_rotation_matrix.sv
